// ----- src/binned_mean_accumulator_macros.svh -----
// Assertion macros used by the checker of the binned mean accumulator.
`ifndef BINNED_MEAN_ACCUMULATOR_MACROS_SVH
`define BINNED_MEAN_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define BMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bma check failed");

// Next-cycle implication, masked while reset is held.
`define BMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bma check failed");

// Next-cycle implication that also holds through reset.
`define BMA_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("bma reset check failed");

`endif

// ----- src/bma_pkg.sv -----
package bma_pkg;

    // Geometry
    localparam int BINS       = 32768;
    localparam int BIN_W      = $clog2(BINS);
    localparam int COUNT_BITS = 20;
    localparam int SUM_W      = 52;
    localparam int WORD_W     = SUM_W + COUNT_BITS;
    localparam int STEP_W     = $clog2(SUM_W + 1);

    // Field widths
    localparam int IDX_W    = 17;
    localparam int SAMPLE_W = 32;
    localparam int NUM_W    = 16;
    localparam int MEAN_W   = 32;
    localparam int HIT_W    = 20;

    localparam int IN_DATA_W  = 8 * ((IDX_W + SAMPLE_W + 7) / 8);
    localparam int OUT_FLD_W  = NUM_W + MEAN_W + HIT_W;
    localparam int OUT_DATA_W = 8 * ((OUT_FLD_W + 7) / 8);
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

    // Saturation limits
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [HIT_W-1:0]      HIT_MAX   = {HIT_W{1'b1}};
    localparam logic [MEAN_W-1:0]     MEAN_MAX  = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0]     MEAN_MIN  = {1'b1, {(MEAN_W-1){1'b0}}};
    localparam logic [SUM_W-1:0]      Q_POS_LIM = SUM_W'(MEAN_MAX);
    localparam logic [SUM_W-1:0]      Q_NEG_LIM = SUM_W'(MEAN_MIN);

    // Function codes
    localparam logic FUNC_ACC  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Bin memory write port
    typedef struct packed {
        logic              en;
        logic [BIN_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } t_ram_wr;

endpackage

// ----- src/bma_ram.sv -----
module bma_ram
    import bma_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [BIN_W-1:0]  i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data
);

    // Entry layout: {count, sum}
    logic [WORD_W-1:0] r_mem [BINS];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/bma_div.sv -----
module bma_div
    import bma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SUM_W-1:0]      i_dividend,
    input  logic [COUNT_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [SUM_W-1:0]      o_quotient
);

    // Restoring divider, one quotient bit per cycle
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [SUM_W-1:0]      r_q, n_q;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [COUNT_BITS-1:0] r_dvs, n_dvs;
    logic [COUNT_BITS:0]   shifted;
    logic [COUNT_BITS:0]   diff;

    assign shifted = {r_rem, r_q[SUM_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(SUM_W);
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // trial subtract; keep it when it does not go negative
            if (!diff[COUNT_BITS]) begin
                n_rem = diff[COUNT_BITS-1:0];
                n_q   = {r_q[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[COUNT_BITS-1:0];
                n_q   = {r_q[SUM_W-2:0], 1'b0};
            end
            n_step = r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ----- src/binned_mean_accumulator.sv -----
// Binned mean accumulator: per-bin sum and hit count in one read-modify-write memory.
// Accumulate: memory read, then saturating add and write back.
// Readout: a non-empty bin goes through the 52-step divider before its result is registered;
//   an empty bin or bad index skips the divider; the next transfer is accepted once the result is registered.
// Reset (synchronous, active low): a clearing pass writes zero to all 32768 bins,
//   one per cycle; no item is accepted until the pass is done.
module binned_mean_accumulator
    import bma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // bin_index[16:0], sample_value[48:17]
    input  logic                  i_s_tuser,   // func
    // master side
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // bin_number[15:0], bin_mean[47:16],
                                               // hit_total[67:48]
    output logic                  o_m_tuser    // bin_empty
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MOD   = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [BIN_W-1:0]      r_clr_addr, n_clr_addr;
    logic                  r_o_valid, n_o_valid;

    logic                  r_func;
    logic [IDX_W-1:0]      r_idx;
    logic [SAMPLE_W-1:0]   r_sample;
    logic                  r_in_rng;
    logic                  r_neg;
    logic                  r_zero;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic                  r_o_user;

    logic                  s_xfer;
    logic                  out_free;
    logic [IDX_W-1:0]      in_idx;
    logic [SAMPLE_W-1:0]   in_sample;
    logic                  in_rng;

    t_ram_wr               ram_wr;
    logic                  rd_en;
    logic [WORD_W-1:0]     rd_data;
    logic [SUM_W-1:0]      rd_sum;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [SUM_W:0]        sum_ext;
    logic [SUM_W-1:0]      sum_sat;
    logic [SUM_W-1:0]      sum_mag;

    logic                  div_start;
    logic                  div_done;
    logic [SUM_W-1:0]      div_q;

    logic [MEAN_W-1:0]     mean;
    logic [31:0]           cnt_ext;
    logic [HIT_W-1:0]      hit;

    // Input side
    assign o_s_tready = (r_state == S_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign in_idx     = i_s_tdata[IDX_W-1:0];
    assign in_sample  = i_s_tdata[IDX_W+SAMPLE_W-1:IDX_W];
    // a negative index reads as >= 2^16 unsigned, so one compare covers both ends
    assign in_rng     = (in_idx < IDX_W'(BINS));
    assign out_free   = !r_o_valid || i_m_tready;

    // Bin memory
    assign rd_en = s_xfer && in_rng;

    bma_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (in_idx[BIN_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_sum = rd_data[SUM_W-1:0];
    assign rd_cnt = rd_data[WORD_W-1:SUM_W];

    // Saturating sum update
    assign sum_ext = {rd_sum[SUM_W-1], rd_sum}
                   + {{(SUM_W+1-SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
    always_comb begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
    end
    assign sum_mag = rd_sum[SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;

    // Write port: clearing pass, accumulate write back, readout clear
    always_comb begin
        ram_wr.en   = 1'b0;
        ram_wr.addr = r_idx[BIN_W-1:0];
        ram_wr.data = '0;
        if (r_state == S_CLEAR) begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = r_clr_addr;
        end else if (r_state == S_MOD && r_in_rng) begin
            if (r_func == FUNC_ACC) begin
                // a full count drops the sample whole
                ram_wr.en   = (rd_cnt != COUNT_MAX);
                ram_wr.data = {rd_cnt + 1'b1, sum_sat};
            end else begin
                ram_wr.en = 1'b1;
            end
        end
    end

    // Mean divider
    assign div_start = (r_state == S_MOD) && (r_func == FUNC_READ) && r_in_rng
                       && (rd_cnt != '0);

    bma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_mag),
        .i_divisor  (rd_cnt),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Clamp and sign of the mean
    always_comb begin
        if (r_zero) begin
            mean = '0;
        end else if (!r_neg) begin
            mean = (div_q > Q_POS_LIM) ? MEAN_MAX : div_q[MEAN_W-1:0];
        end else begin
            mean = (div_q > Q_NEG_LIM) ? MEAN_MIN : (~div_q[MEAN_W-1:0] + 1'b1);
        end
    end

    assign cnt_ext = 32'(r_cnt);
    assign hit     = (cnt_ext > 32'(HIT_MAX)) ? HIT_MAX : cnt_ext[HIT_W-1:0];

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_o_valid  = r_o_valid && !i_m_tready;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == BIN_W'(BINS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_xfer) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (r_func == FUNC_ACC) begin
                    n_state = S_IDLE;
                end else if (div_start) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_o_valid  <= n_o_valid;
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_func   <= i_s_tuser;
            r_idx    <= in_idx;
            r_sample <= in_sample;
            r_in_rng <= in_rng;
        end
        if (r_state == S_MOD) begin
            r_neg  <= rd_sum[SUM_W-1];
            r_zero <= !div_start;
            r_cnt  <= r_in_rng ? rd_cnt : '0;
        end
        if (r_state == S_OUT && out_free) begin
            r_o_data <= {{OUT_PAD_W{1'b0}}, hit, mean, r_idx[NUM_W-1:0]};
            r_o_user <= r_zero;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;

endmodule

// ----- src/bma_checker.sv -----
`include "binned_mean_accumulator_macros.svh"

module bma_checker
    import bma_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tuser
);

    // reset empties the result register
    `BMA_ASSERT_RST(a_rst_no_result, !i_rst_n, !o_m_tvalid)

    // one item at a time: an accepted transfer keeps the block busy next cycle
    `BMA_ASSERT_NEXT(a_busy_after_xfer, i_s_tvalid && o_s_tready, !o_s_tready)

    // a stalled result holds
    `BMA_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready,
                     o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // an empty bin shows a zero mean and a zero count
    `BMA_ASSERT_NOW(a_empty_zero, o_m_tvalid && o_m_tuser,
                    o_m_tdata[47:16] == '0 && o_m_tdata[67:48] == '0)

    // a bin that is not empty shows a nonzero count
    `BMA_ASSERT_NOW(a_full_count, o_m_tvalid && !o_m_tuser, o_m_tdata[67:48] != '0)

endmodule

bind binned_mean_accumulator bma_checker u_bma_checker (.*);

// ----- dv/binned_mean_accumulator_tb.sv -----
module binned_mean_accumulator_tb;
    import bma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_OPS  = 1030;
    localparam int DRAIN_OPS   = 600;   // random op that waits for all readouts first
    localparam int TAIL_CYCLES = 120;
    localparam int LONG_HOLD   = 600;
    localparam int HOT_BINS    = 8;

    localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));

    typedef struct {
        logic                       func;
        logic signed [IDX_W-1:0]    idx;
        logic signed [SAMPLE_W-1:0] sample;
        bit                         wait_idle;
    } t_bin_op;

    typedef struct {
        logic [NUM_W-1:0]  number;
        logic [MEAN_W-1:0] mean;
        logic [HIT_W-1:0]  hits;
        logic              empty;
    } t_readout;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;     // bin_index[16:0], sample_value[48:17]
    logic                  s_tuser;     // func
    logic                  o_m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // bin_number[15:0], bin_mean[47:16],
                                        // hit_total[67:48]
    logic                  o_m_tuser;   // bin_empty

    binned_mean_accumulator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    t_bin_op  pending_ops[$];
    t_readout expected_readouts[$];

    // Shadow of the bin memory; absent keys are zero
    longint      bin_sum_shadow[int];
    int unsigned bin_hits_shadow[int];

    int fail_count;
    int cycle_count;
    int ops_sent;
    int acc_sent;
    int read_sent;
    int readouts_seen;
    int empty_seen;
    int hot_bin[HOT_BINS];

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Applies one transfer to the shadow bins; returns 1 when it yields a readout
    function automatic bit apply_bin_op(input t_bin_op op, output t_readout res);
        int          b;
        bit          in_range;
        longint      sum;
        longint      mean;
        int unsigned hits;
        b        = int'(op.idx);
        in_range = (b >= 0) && (b < BINS);
        res      = '{default: '0};
        if (op.func == FUNC_ACC) begin
            if (in_range) begin
                hits = bin_hits_shadow.exists(b) ? bin_hits_shadow[b] : 0;
                sum  = bin_sum_shadow.exists(b) ? bin_sum_shadow[b] : 0;
                // full count drops the sample whole
                if (hits < COUNT_MAX) begin
                    sum = sum + longint'(op.sample);
                    if (sum > SUM_HI) sum = SUM_HI;
                    if (sum < SUM_LO) sum = SUM_LO;
                    bin_sum_shadow[b]  = sum;
                    bin_hits_shadow[b] = hits + 1;
                end
            end
            return 1'b0;
        end
        hits = 0;
        mean = 0;
        if (in_range) begin
            hits = bin_hits_shadow.exists(b) ? bin_hits_shadow[b] : 0;
            sum  = bin_sum_shadow.exists(b) ? bin_sum_shadow[b] : 0;
            if (hits > 0) begin
                mean = sum / longint'(hits);
                if (mean > longint'($signed(MEAN_MAX))) mean = longint'($signed(MEAN_MAX));
                if (mean < longint'($signed(MEAN_MIN))) mean = longint'($signed(MEAN_MIN));
            end
            bin_sum_shadow[b]  = 0;
            bin_hits_shadow[b] = 0;
        end
        res.number = op.idx[NUM_W-1:0];
        res.mean   = mean[MEAN_W-1:0];
        res.hits   = (hits > HIT_MAX) ? HIT_MAX : hits[HIT_W-1:0];
        res.empty  = (hits == 0);
        return 1'b1;
    endfunction

    // Idle length: mostly none, some short, a few long; none in quiet stretches
    function automatic int pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Source driver
    int       src_gap;
    t_bin_op  cur_op;
    t_readout pred;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= FUNC_ACC;
            src_gap  = 0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                if (apply_bin_op(cur_op, pred)) expected_readouts.push_back(pred);
                ops_sent++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0 &&
                             !(pending_ops[0].wait_idle && expected_readouts.size() > 0)) begin
                    cur_op = pending_ops.pop_front();
                    s_tdata  <= {{(IN_DATA_W-IDX_W-SAMPLE_W){1'b0}}, cur_op.sample, cur_op.idx};
                    s_tuser  <= cur_op.func;
                    s_tvalid <= 1'b1;
                    src_gap  = pick_gap((ops_sent % 128) < 32);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink monitor and checker
    int       rx_stall;
    bit       long_hold_done;
    int       g;
    t_readout exp_r;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready       <= 1'b0;
            rx_stall       = 0;
            long_hold_done = 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                readouts_seen++;
                if (o_m_tuser) empty_seen++;
                if (expected_readouts.size() == 0) begin
                    $error("unexpected readout transfer: tdata %h", o_m_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_readouts.pop_front();
                    if (o_m_tdata[15:0] !== exp_r.number) begin
                        $error("bin_number mismatch: expected %0d actual %0d",
                               exp_r.number, o_m_tdata[15:0]);
                        fail_count++;
                    end
                    if (o_m_tdata[47:16] !== exp_r.mean) begin
                        $error("bin_mean mismatch: expected %0d actual %0d",
                               $signed(exp_r.mean), $signed(o_m_tdata[47:16]));
                        fail_count++;
                    end
                    if (o_m_tdata[67:48] !== exp_r.hits) begin
                        $error("hit_total mismatch: expected %0d actual %0d",
                               exp_r.hits, o_m_tdata[67:48]);
                        fail_count++;
                    end
                    if (o_m_tuser !== exp_r.empty) begin
                        $error("bin_empty mismatch: expected %0d actual %0d",
                               exp_r.empty, o_m_tuser);
                        fail_count++;
                    end
                end
            end
            // one long back-pressure stretch early on, random gaps otherwise
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && readouts_seen >= 20) begin
                long_hold_done = 1'b1;
                rx_stall = LONG_HOLD;
                m_tready <= 1'b0;
            end else begin
                g = pick_gap((readouts_seen % 16) < 4);
                if (g == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    rx_stall = g - 1;
                end
            end
        end
    end

    task automatic add_op(input logic func, input int idx, input longint sample,
                          input bit wait_idle = 1'b0);
        t_bin_op op;
        op.func      = func;
        op.idx       = idx[IDX_W-1:0];
        op.sample    = sample[SAMPLE_W-1:0];
        op.wait_idle = wait_idle;
        pending_ops.push_back(op);
        if (func == FUNC_ACC) acc_sent++;
        else read_sent++;
    endtask

    function automatic int rand_bad_idx();
        if ($urandom_range(0, 1) == 0) return -int'($urandom_range(1, 65536));
        return $urandom_range(BINS, 65535);
    endfunction

    function automatic int rand_idx(input int pct_hot);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < pct_hot) return hot_bin[$urandom_range(0, HOT_BINS - 1)];
        if (r < pct_hot + (100 - pct_hot) / 2) return $urandom_range(0, BINS - 1);
        return rand_bad_idx();
    endfunction

    function automatic longint rand_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return longint'($signed(MEAN_MAX));
        if (r < 24) return longint'($signed(MEAN_MIN));
        if (r < 40) return longint'($urandom_range(0, 2000)) - 1000;
        return longint'($signed($urandom()));
    endfunction

    // Stimulus and end of run
    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_ACC;
        m_tready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        ops_sent = 0;
        acc_sent = 0;
        read_sent = 0;
        readouts_seen = 0;
        empty_seen = 0;

        hot_bin[0] = 0;
        hot_bin[1] = BINS - 1;
        for (int i = 2; i < HOT_BINS; i++) hot_bin[i] = $urandom_range(0, BINS - 1);

        // extreme samples cancel; mean truncates toward zero
        add_op(FUNC_ACC, 0, longint'($signed(MEAN_MAX)));
        add_op(FUNC_ACC, 0, longint'($signed(MEAN_MIN)));
        add_op(FUNC_READ, 0, 0);
        add_op(FUNC_READ, 0, 0);                        // cleared bin reads empty
        add_op(FUNC_ACC, BINS - 1, -3);
        add_op(FUNC_ACC, BINS - 1, -4);
        // indices outside the bin range change nothing
        add_op(FUNC_ACC, -1, 1000);
        add_op(FUNC_ACC, -65536, 1000);
        add_op(FUNC_ACC, BINS, 1000);
        add_op(FUNC_ACC, 65535, 1000);
        add_op(FUNC_READ, BINS - 1, 0);
        add_op(FUNC_READ, -1, 0);
        add_op(FUNC_READ, 65535, 0);
        add_op(FUNC_READ, BINS, 0);
        add_op(FUNC_READ, -65536, 0);
        // mean at the top and bottom of its range
        repeat (3) add_op(FUNC_ACC, 5, longint'($signed(MEAN_MAX)));
        add_op(FUNC_READ, 5, 0);
        repeat (2) add_op(FUNC_ACC, 6, longint'($signed(MEAN_MIN)));
        add_op(FUNC_READ, 6, 0);
        // sample field is ignored on a readout
        add_op(FUNC_ACC, 7, 1);
        add_op(FUNC_READ, 7, longint'($signed(MEAN_MIN)));

        // random: mostly accumulates into a few hot bins, with readouts of them
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if ($urandom_range(0, 99) < 78)
                add_op(FUNC_ACC, rand_idx(80), rand_sample(), i == DRAIN_OPS);
            else
                add_op(FUNC_READ, rand_idx(85), rand_sample(), i == DRAIN_OPS);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid) @(posedge i_clk);
        while (expected_readouts.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d transfers in (%0d accumulates, %0d readouts) over %0d cycles",
                 ops_sent, acc_sent, read_sent, cycle_count);
        $display("%0d readouts checked, %0d of them empty or out of range",
                 readouts_seen, empty_seen);
        if (fail_count == 0 && expected_readouts.size() == 0) begin
            $display("binned_mean_accumulator test passed");
        end else begin
            $display("binned_mean_accumulator test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("binned_mean_accumulator test failed");
        $finish;
    end

endmodule
